/* rtl/core/matrix_multiply_engine_unit_assert.svh */
// Assertion macros used by the checker of the matrix multiply engine.
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mme_pkg.sv */
// Package with the types and constants of the matrix multiply engine.
package mme_pkg;

   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int FRAC_W      = 16;
   localparam int CSR_DATA_W  = 4;
   localparam int IDX_FIELD_W = 4;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 4'd8;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_ISSUE,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [2:0]               elem_row;
      logic [2:0]               elem_col;
      logic signed [DATA_W-1:0] elem_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prod_value;
      logic [2:0]               prod_row;
      logic [2:0]               prod_col;
      logic                     last;
      logic                     status;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] a_rows;
      logic [CSR_DATA_W-1:0] a_cols;
      logic [CSR_DATA_W-1:0] b_rows;
      logic [CSR_DATA_W-1:0] b_cols;
   } dims_type;

   // Controller to datapath.
   typedef struct packed {
      logic                   wr_a;
      logic                   wr_b;
      logic [IDX_FIELD_W-1:0] wr_row;
      logic [IDX_FIELD_W-1:0] wr_col;
      logic                   rd_en;
      logic [IDX_FIELD_W-1:0] rd_i;
      logic [IDX_FIELD_W-1:0] rd_j;
      logic [IDX_FIELD_W-1:0] rd_k;
      logic                   first;
      logic                   fin;
      logic                   last_elem;
      logic                   err_load;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
      logic res_done;
   } dp_status_type;

   // Tag that travels along the multiply-accumulate pipeline.
   typedef struct packed {
      logic       first;
      logic       fin;
      logic       last_elem;
      logic [2:0] row;
      logic [2:0] col;
   } mac_tag_type;

endpackage

/* rtl/core/mme_ctrl.sv */
// Controller state machine of the matrix multiply engine.
module mme_ctrl
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_cmd,
   input  logic [2:0]    req_row,
   input  logic [2:0]    req_col,
   input  dims_type      dims,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // Clamp a dimension register to 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] used_dim(input logic [CSR_DATA_W-1:0] v);
      if (v == '0) return DIM_W'(1);
      if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
      return DIM_W'(v);
   endfunction

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] nr, nk, nc, nb;
   logic             mismatch, in_range, k_end, i_end, j_end;

   assign nr       = used_dim(dims.a_rows);
   assign nk       = used_dim(dims.a_cols);
   assign nb       = used_dim(dims.b_rows);
   assign nc       = used_dim(dims.b_cols);
   assign mismatch = (nk != nb);
   assign in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign k_end    = (DIM_W'(k_ff) == nk - DIM_W'(1));
   assign i_end    = (DIM_W'(i_ff) == nr - DIM_W'(1));
   assign j_end    = (DIM_W'(j_ff) == nc - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      k_in             = k_ff;
      req_ready        = 1'b0;
      dp_cmd           = '0;
      dp_cmd.wr_row    = IDX_FIELD_W'(req_row);
      dp_cmd.wr_col    = IDX_FIELD_W'(req_col);
      dp_cmd.rd_i      = IDX_FIELD_W'(i_ff);
      dp_cmd.rd_j      = IDX_FIELD_W'(j_ff);
      dp_cmd.rd_k      = IDX_FIELD_W'(k_ff);
      dp_cmd.first     = (k_ff == '0);
      dp_cmd.fin       = k_end;
      dp_cmd.last_elem = i_end && j_end;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD_A: dp_cmd.wr_a = in_range;
                  CMD_LOAD_B: dp_cmd.wr_b = in_range;
                  CMD_COMPUTE: begin
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            // wait for the output slot, then report an error or start the element
            if (dp_status.out_free) begin
               if (mismatch) begin
                  dp_cmd.err_load = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            dp_cmd.rd_en = 1'b1;
            if (k_end) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (dp_status.res_done) begin
               if (i_end && j_end) begin
                  state_in = ST_IDLE;
               end else begin
                  if (j_end) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/core/mme_datapath.sv */
// Datapath of the matrix multiply engine: element stores, MAC pipeline, result register.
module mme_datapath
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               dp_cmd,
   input  logic signed [DATA_W-1:0] wr_value,
   output dp_status_type            dp_status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   logic signed [DATA_W-1:0] a_mem [DEPTH];
   logic signed [DATA_W-1:0] b_mem [DEPTH];

   logic [ADDR_W-1:0]        wr_addr, a_rd_addr, b_rd_addr;
   logic signed [DATA_W-1:0] a_rd_ff, b_rd_ff;
   logic signed [ACC_W-1:0]  prod_ff, acc_ff, acc_in;
   logic                     v1_ff, v2_ff, v3_ff;
   mac_tag_type              tag0, tag1_ff, tag2_ff, tag3_ff;
   logic signed [DATA_W-1:0] sat_value;
   logic                     rsp_valid_ff, load;
   rsp_type                  rsp_data_ff, rsp_data_in;

   assign wr_addr   = {dp_cmd.wr_row[IDX_W-1:0], dp_cmd.wr_col[IDX_W-1:0]};
   assign a_rd_addr = {dp_cmd.rd_i[IDX_W-1:0], dp_cmd.rd_k[IDX_W-1:0]};
   assign b_rd_addr = {dp_cmd.rd_k[IDX_W-1:0], dp_cmd.rd_j[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (dp_cmd.wr_a) a_mem[wr_addr] <= wr_value;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.wr_b) b_mem[wr_addr] <= wr_value;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rd_en) begin
         a_rd_ff <= a_mem[a_rd_addr];
         b_rd_ff <= b_mem[b_rd_addr];
      end
   end

   assign tag0.first     = dp_cmd.first;
   assign tag0.fin       = dp_cmd.fin;
   assign tag0.last_elem = dp_cmd.last_elem;
   assign tag0.row       = 3'(dp_cmd.rd_i);
   assign tag0.col       = 3'(dp_cmd.rd_j);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= dp_cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && tag2_ff.fin;
      end
   end

   assign acc_in = tag2_ff.first ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      tag1_ff <= tag0;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      prod_ff <= ACC_W'(a_rd_ff) * ACC_W'(b_rd_ff);
      if (v2_ff) acc_ff <= acc_in;
   end

   // Scale Q32.32 to Q16.16 (arithmetic shift) and clamp to 32 bits.
   always_comb begin
      if (!acc_ff[ACC_W-1] && (|acc_ff[ACC_W-2:DATA_W+FRAC_W-1])) begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (acc_ff[ACC_W-1] && !(&acc_ff[ACC_W-2:DATA_W+FRAC_W-1])) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = acc_ff[DATA_W+FRAC_W-1:FRAC_W];
      end
   end

   assign load = v3_ff || dp_cmd.err_load;

   always_comb begin
      if (dp_cmd.err_load) begin
         rsp_data_in.prod_value = '0;
         rsp_data_in.prod_row   = '0;
         rsp_data_in.prod_col   = '0;
         rsp_data_in.last       = 1'b1;
         rsp_data_in.status     = STATUS_MISMATCH;
      end else begin
         rsp_data_in.prod_value = sat_value;
         rsp_data_in.prod_row   = tag3_ff.row;
         rsp_data_in.prod_col   = tag3_ff.col;
         rsp_data_in.last       = tag3_ff.last_elem;
         rsp_data_in.status     = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;
   assign dp_status.res_done = v3_ff;

endmodule

/* rtl/core/matrix_multiply_engine_unit.sv */
// Top level of the matrix multiply engine: dimension registers, controller and datapath.
//
//   channel   dir  handshake              payload
//   req       in   req_valid / req_ready  req_data  (req_type: cmd, elem_row, elem_col, value)
//   rsp       out  rsp_valid / rsp_ready  rsp_data  (rsp_type: value, row, col, last, status)
//   csr       in   csr_valid / csr_ready  csr_index, csr_wdata (a_rows, a_cols, b_rows, b_cols)
//
// A load beat keeps the block idle, so it is ready again in the next cycle.
// A compute beat runs R*C product elements with R, K, C the clamped dimensions:
// a start step, K store reads through one shared multiply-accumulate unit and a
// drain per product element; an inner mismatch ends it with a lone error result.
// A result held in the output register stalls the next element; a load can still
// be taken while the last result waits. Synchronous reset clears control state and
// sets all dimensions to 8; the stores are not cleared.
module matrix_multiply_engine_unit
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dims_type      dims_ff;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Dimension registers accept a write on every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.a_rows <= DIM_RESET;
         dims_ff.a_cols <= DIM_RESET;
         dims_ff.b_rows <= DIM_RESET;
         dims_ff.b_cols <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_A_ROWS: dims_ff.a_rows <= csr_wdata;
            CSR_A_COLS: dims_ff.a_cols <= csr_wdata;
            CSR_B_ROWS: dims_ff.b_rows <= csr_wdata;
            CSR_B_COLS: dims_ff.b_cols <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequence loads and the row, column and inner loops.
   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .req_row   (req_data.elem_row),
      .req_col   (req_data.elem_col),
      .dims      (dims_ff),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Hold the stores, run the MAC pipeline and drive the result beat.
   mme_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .wr_value  (req_data.elem_value),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/mme_checker.sv */
// Port checker of the matrix multiply engine and its bind to the top level.
`include "matrix_multiply_engine_unit_assert.svh"

module mme_checker
   import mme_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic compute_beat;
   logic err_shape;

   assign compute_beat = req_valid && req_ready && (req_data.cmd == CMD_COMPUTE);
   assign err_shape    = rsp_data.last && (rsp_data.prod_value == '0)
                         && (rsp_data.prod_row == '0) && (rsp_data.prod_col == '0);

   `MME_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat dropped or changed while stalled")
   `MME_ASSERT_NXT(a_busy_after_compute, clock, reset, compute_beat, !req_ready, "request taken right after a compute beat")
   `MME_ASSERT_IMP(a_err_shape, clock, reset, rsp_valid && (rsp_data.status == STATUS_MISMATCH), err_shape, "mismatch result is not a lone zero beat")
   `MME_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "result appeared while idle")

endmodule

bind matrix_multiply_engine_unit mme_checker u_checker (.*);
